// File: rtl/rhnc_pkg.sv
package rhnc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned VB_W   = 3;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SUM_W  = 42;

  // Word indexes within the header
  localparam logic [CNT_W-1:0] IDX_REGION      = 11'd15;
  localparam logic [CNT_W-1:0] IDX_SUM_FIRST   = 11'd16;
  localparam logic [CNT_W-1:0] IDX_ARCADE_LAST = 11'd767;
  localparam logic [CNT_W-1:0] IDX_CLASS       = 11'd1023;
  localparam logic [CNT_W-1:0] CNT_SAT         = 11'd1024;

  typedef enum logic [1:0] {
    ORD_BIG     = 2'd0,
    ORD_SWAP    = 2'd1,
    ORD_LITTLE  = 2'd2,
    ORD_UNKNOWN = 2'd3
  } order_e;

  typedef enum logic [3:0] {
    CIC_6101 = 4'd0,
    CIC_6102 = 4'd1,
    CIC_7101 = 4'd2,
    CIC_7102 = 4'd3,
    CIC_6103 = 4'd4,
    CIC_7103 = 4'd5,
    CIC_6105 = 4'd6,
    CIC_7105 = 4'd7,
    CIC_6106 = 4'd8,
    CIC_7106 = 4'd9,
    CIC_8303 = 4'd10,
    CIC_8401 = 4'd11,
    CIC_5167 = 4'd12,
    CIC_DDUS = 4'd13,
    CIC_5101 = 4'd14
  } cic_e;

  typedef struct packed {
    logic is_pal;
    cic_e code;
    logic known;
  } class_t;

endpackage

// File: rtl/rhnc_in_if.sv
interface rhnc_in_if;
  import rhnc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] raw_word;
  logic [VB_W-1:0]   valid_bytes;
  logic              first_word;

  modport source (output valid, output raw_word, output valid_bytes, output first_word,
                  input ready);
  modport sink   (input valid, input raw_word, input valid_bytes, input first_word,
                  output ready);
endinterface

// File: rtl/rhnc_out_if.sv
interface rhnc_out_if;
  import rhnc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] norm_word;
  logic [1:0]        byte_order;
  logic              class_valid;
  logic              is_pal;
  logic [3:0]        cic_code;
  logic              cic_known;

  modport source (output valid, output norm_word, output byte_order, output class_valid,
                  output is_pal, output cic_code, output cic_known, input ready);
  modport sink   (input valid, input norm_word, input byte_order, input class_valid,
                  input is_pal, input cic_code, input cic_known, output ready);
endinterface

// File: rtl/rhnc_norm.sv
module rhnc_norm (
  input  logic [rhnc_pkg::WORD_W-1:0] raw_word_i,
  input  logic [rhnc_pkg::VB_W-1:0]   valid_bytes_i,
  input  logic                        first_word_i,
  input  rhnc_pkg::order_e            order_q_i,
  output rhnc_pkg::order_e            order_o,
  output logic [rhnc_pkg::WORD_W-1:0] norm_word_o
);
  import rhnc_pkg::*;

  localparam logic [WORD_W-1:0] HDR_BIG_A = 32'h40123780;
  localparam logic [WORD_W-1:0] HDR_BIG_B = 32'h40072780;
  localparam logic [WORD_W-1:0] HDR_BIG_C = 32'h41123780;
  localparam logic [WORD_W-1:0] HDR_SWP_A = 32'h12408037;
  localparam logic [WORD_W-1:0] HDR_SWP_B = 32'h07408027;
  localparam logic [WORD_W-1:0] HDR_SWP_C = 32'h12418037;
  localparam logic [WORD_W-1:0] HDR_LIT_A = 32'h80371240;
  localparam logic [WORD_W-1:0] HDR_LIT_B = 32'h80270740;
  localparam logic [WORD_W-1:0] HDR_LIT_C = 32'h80371241;

  localparam logic [7:0] LB_BIG    = 8'h80;
  localparam logic [7:0] LB_SWP_A  = 8'h37;
  localparam logic [7:0] LB_SWP_B  = 8'h27;
  localparam logic [7:0] LB_LIT_A  = 8'h40;
  localparam logic [7:0] LB_LIT_B  = 8'h41;

  function automatic order_e pick_order(input logic [WORD_W-1:0] w);
    order_e o;
    unique case (w)
      HDR_BIG_A, HDR_BIG_B, HDR_BIG_C: o = ORD_BIG;
      HDR_SWP_A, HDR_SWP_B, HDR_SWP_C: o = ORD_SWAP;
      HDR_LIT_A, HDR_LIT_B, HDR_LIT_C: o = ORD_LITTLE;
      default: begin
        // fall back on the low byte alone
        unique case (w[7:0])
          LB_BIG:             o = ORD_BIG;
          LB_SWP_A, LB_SWP_B: o = ORD_SWAP;
          LB_LIT_A, LB_LIT_B: o = ORD_LITTLE;
          default:            o = ORD_UNKNOWN;
        endcase
      end
    endcase
    return o;
  endfunction

  logic [WORD_W-1:0] masked;
  logic              full;
  logic              pair;

  assign order_o = first_word_i ? pick_order(raw_word_i) : order_q_i;

  always_comb begin
    full = 1'b1;
    pair = 1'b1;
    unique case (valid_bytes_i)
      3'd1: begin
        masked = {24'd0, raw_word_i[7:0]};
        full   = 1'b0;
        pair   = 1'b0;
      end
      3'd2: begin
        masked = {16'd0, raw_word_i[15:0]};
        full   = 1'b0;
      end
      3'd3: begin
        masked = {8'd0, raw_word_i[23:0]};
        full   = 1'b0;
      end
      default: masked = raw_word_i;  // zero and four to seven count as a full word
    endcase
  end

  always_comb begin
    norm_word_o = masked;
    unique case (order_o)
      ORD_SWAP: begin
        if (full) begin
          norm_word_o = {masked[23:16], masked[31:24], masked[7:0], masked[15:8]};
        end else if (pair) begin
          norm_word_o = {masked[31:16], masked[7:0], masked[15:8]};
        end
      end
      ORD_LITTLE: begin
        if (full) begin
          norm_word_o = {masked[7:0], masked[15:8], masked[23:16], masked[31:24]};
        end
      end
      ORD_BIG, ORD_UNKNOWN: norm_word_o = masked;
      default:              norm_word_o = masked;
    endcase
  end
endmodule

// File: rtl/rhnc_classify.sv
module rhnc_classify (
  input  logic [rhnc_pkg::SUM_W-1:0] main_sum_i,
  input  logic [rhnc_pkg::SUM_W-1:0] arcade_sum_i,
  input  logic [7:0]                 region_char_i,
  output rhnc_pkg::class_t           class_o
);
  import rhnc_pkg::*;

  typedef struct packed {
    logic hit;
    logic is_pal;
    cic_e code;
  } sig_t;

  function automatic logic region_is_pal(input logic [7:0] c);
    logic p;
    unique case (c)
      8'h44, 8'h46, 8'h48, 8'h49, 8'h4c, 8'h50,       // D F H I L P
      8'h53, 8'h55, 8'h57, 8'h58, 8'h59: p = 1'b1;    // S U W X Y
      default:                           p = 1'b0;
    endcase
    return p;
  endfunction

  function automatic sig_t match_sig(input logic [SUM_W-1:0] s, input logic pal);
    sig_t r;
    r.hit    = 1'b1;
    r.is_pal = pal;
    r.code   = CIC_6101;
    unique case (s)
      42'h0a316adc55a, 42'h0a30dacd530, 42'h0039c981107,
      42'h0d2828281b0, 42'h09acc31e644, 42'h09474732e6b:
        r.code = pal ? CIC_7101 : CIC_6102;
      42'h0a405397b05, 42'h0a3fc388adb: begin
        r.is_pal = 1'b1;
        r.code   = CIC_7102;
      end
      42'h0a0f26f62fe, 42'h0a0e96e72d4: begin
        r.is_pal = 1'b0;
        r.code   = CIC_6101;
      end
      42'h0a9229d7c45, 42'h0a9199c8c1b, 42'h0271316d406:
        r.code = pal ? CIC_7103 : CIC_6103;
      42'h0f8b860ed00, 42'h0f8af5ffcd6:
        r.code = pal ? CIC_7105 : CIC_6105;
      42'h0ba5ba4b8cd:
        r.code = pal ? CIC_7106 : CIC_6106;
      42'h12daafc8aab: r.code = CIC_5167;
      42'h0a9df4b39e1: r.code = CIC_8303;
      42'h0aa764e39e1: r.code = CIC_8401;
      42'h0abb0b739e1: r.code = CIC_DDUS;
      42'h081ce470326, 42'h0827a47195a, 42'h082551e4848:
        r.code = CIC_5101;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  logic pal_region;
  sig_t main_m;
  sig_t arc_m;

  assign pal_region = region_is_pal(region_char_i);
  assign main_m     = match_sig(main_sum_i, pal_region);
  assign arc_m      = match_sig(arcade_sum_i, pal_region);

  // main sum wins, then arcade sum, then the region default
  always_comb begin
    priority if (main_m.hit) begin
      class_o = '{is_pal: main_m.is_pal, code: main_m.code, known: 1'b1};
    end else if (arc_m.hit) begin
      class_o = '{is_pal: arc_m.is_pal, code: arc_m.code, known: 1'b1};
    end else begin
      class_o = '{is_pal: pal_region, code: (pal_region ? CIC_7101 : CIC_6102),
                  known: 1'b0};
    end
  end
endmodule

// File: rtl/rom_header_normalize_classify_core.sv
// ROM header normaliser and boot chip / region classifier.
//
// in_i carries one beat per 32-bit ROM word (file byte 0 in bits 7:0), with
// valid_bytes for a short last word and first_word on the first beat of a
// file. The first word picks the byte order for the whole file. out_o gives
// one beat per input beat: the word in big-endian file order, the byte order
// in use, and on the beat for header word 1023 the classification (region,
// boot chip code, and whether a checksum signature matched).
//
// An accepted input beat reaches its output beat through the input register,
// the normalise/accumulate register and the result register. One beat
// per cycle is sustained while the receiver keeps ready high; the 42-bit sum
// update and the signature compare each sit in a stage of their own.
//
// Reset empties the pipeline and sets the order to unknown, the word count,
// sums and region byte to zero. When the receiver stalls, a full stage holds
// and bubbles close up behind it, so ready stays high until all three stages
// hold a beat.
module rom_header_normalize_classify_core (
  input  logic clk_i,
  input  logic rst_ni,
  rhnc_in_if.sink    in_i,
  rhnc_out_if.source out_o
);
  import rhnc_pkg::*;

  // Stage 1: input register
  logic              v1_q;
  logic [WORD_W-1:0] raw1_q;
  logic [VB_W-1:0]   vb1_q;
  logic              first1_q;

  // Stage 2: normalised word, sums updated on entry
  logic              v2_q;
  logic [WORD_W-1:0] nw2_q;
  order_e            ord2_q;
  logic              cls2_q;

  // Stage 3: result register
  logic              v3_q;
  logic [WORD_W-1:0] nw3_q;
  order_e            ord3_q;
  logic              cls3_q;
  class_t            class3_q;

  // File state
  order_e            order_q,      order_d;
  logic [CNT_W-1:0]  word_count_q, word_count_d;
  logic [SUM_W-1:0]  main_sum_q,   main_sum_d;
  logic [SUM_W-1:0]  arcade_sum_q, arcade_sum_d;
  logic [7:0]        region_q,     region_d;

  logic              ready1, ready2, ready3;
  logic              s1_go, s2_go;
  logic [CNT_W-1:0]  idx;
  logic [WORD_W-1:0] nw;
  class_t            class_c;

  // Elastic handshake: a stage takes a beat when empty or when its own beat leaves
  assign ready3     = !v3_q || out_o.ready;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_i.ready = ready1;
  assign s1_go      = v1_q && ready2;
  assign s2_go      = v2_q && ready3;

  rhnc_norm u_norm (
    .raw_word_i    (raw1_q),
    .valid_bytes_i (vb1_q),
    .first_word_i  (first1_q),
    .order_q_i     (order_q),
    .order_o       (order_d),
    .norm_word_o   (nw)
  );

  // A first word restarts the count at zero
  assign idx = first1_q ? '0 : word_count_q;

  always_comb begin
    word_count_d = (idx >= CNT_SAT) ? CNT_SAT : idx + 11'd1;
    main_sum_d   = first1_q ? '0 : main_sum_q;
    arcade_sum_d = first1_q ? '0 : arcade_sum_q;
    region_d     = first1_q ? '0 : region_q;
    if (idx == IDX_REGION) begin
      region_d = nw[23:16];
    end
    if (idx >= IDX_SUM_FIRST && idx <= IDX_CLASS) begin
      main_sum_d = main_sum_q + SUM_W'(nw);
    end
    if (idx >= IDX_SUM_FIRST && idx <= IDX_ARCADE_LAST) begin
      arcade_sum_d = arcade_sum_q + SUM_W'(nw);
    end
  end

  // Sums seen here already include the beat in stage 2 and nothing later
  rhnc_classify u_classify (
    .main_sum_i    (main_sum_q),
    .arcade_sum_i  (arcade_sum_q),
    .region_char_i (region_q),
    .class_o       (class_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      order_q      <= ORD_UNKNOWN;
      word_count_q <= '0;
      main_sum_q   <= '0;
      arcade_sum_q <= '0;
      region_q     <= '0;
    end else begin
      if (ready1) begin
        v1_q <= in_i.valid;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      // Advance file state as each beat enters stage 2
      if (s1_go) begin
        order_q      <= order_d;
        word_count_q <= word_count_d;
        main_sum_q   <= main_sum_d;
        arcade_sum_q <= arcade_sum_d;
        region_q     <= region_d;
      end
    end
  end

  // Payload registers: hold while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (in_i.valid && ready1) begin
      raw1_q   <= in_i.raw_word;
      vb1_q    <= in_i.valid_bytes;
      first1_q <= in_i.first_word;
    end
    if (s1_go) begin
      nw2_q  <= nw;
      ord2_q <= order_d;
      cls2_q <= (idx == IDX_CLASS);
    end
    if (s2_go) begin
      nw3_q  <= nw2_q;
      ord3_q <= ord2_q;
      cls3_q <= cls2_q;
      // Drop the classification fields on all other words
      class3_q <= cls2_q ? class_c : class_t'{is_pal: 1'b0, code: CIC_6101, known: 1'b0};
    end
  end

  assign out_o.valid       = v3_q;
  assign out_o.norm_word   = nw3_q;
  assign out_o.byte_order  = ord3_q;
  assign out_o.class_valid = cls3_q;
  assign out_o.is_pal      = class3_q.is_pal;
  assign out_o.cic_code    = class3_q.code;
  assign out_o.cic_known   = class3_q.known;

`ifndef SYNTHESIS
  // An unmatched header falls back on the region default
  a_default_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.class_valid && !out_o.cic_known |->
      ((out_o.is_pal && out_o.cic_code == CIC_7101) ||
       (!out_o.is_pal && out_o.cic_code == CIC_6102)))
    else $error("default boot chip code does not follow region");

  // Words without classification carry cleared class fields
  a_no_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.class_valid |->
      (!out_o.is_pal && !out_o.cic_known && out_o.cic_code == CIC_6101))
    else $error("class fields set on an unclassified word");

  // A first word restarts the count and clears the sums
  a_first_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && first1_q |=> (word_count_q == 11'd1 && main_sum_q == '0 &&
                           arcade_sum_q == '0))
    else $error("first word did not restart the file state");

  // The count holds at saturation until the next file
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && !first1_q && word_count_q == CNT_SAT |=> word_count_q == CNT_SAT)
    else $error("word count left saturation");
`endif
endmodule
